/* hw/rtl/wc_pkg.sv */
// Shared types and constants for the window centroid core.
package wc_pkg;

  // Field widths.
  localparam int COORD_W  = 11;
  localparam int INTENS_W = 16;
  localparam int HALF_W   = 5;
  localparam int WEIGHT_W = 26;
  localparam int MOMENT_W = 37;
  localparam int CENT_W   = 19;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;

  // Signed pixel coordinate and coordinate-times-intensity product.
  localparam int SCOORD_W = COORD_W + 2;
  localparam int PROD_W   = SCOORD_W + INTENS_W + 1;

  // Half width limits and reset value.
  localparam logic [HALF_W-1:0] HALF_MIN   = 5'd1;
  localparam logic [HALF_W-1:0] HALF_MAX   = 5'd16;
  localparam logic [HALF_W-1:0] HALF_RESET = 5'd11;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // a pixel beat is taken this cycle
    logic start_div;  // latch the sums into the dividers and clear them
    logic load_out;   // move the finished result into the output register
  } wc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pixel_last; // the pixel on the input is the last one of its window
    logic div_busy;   // the dividers are still iterating
    logic out_free;   // the output register can take a result this cycle
  } wc_stat_t;

endpackage

/* hw/rtl/wc_divider.sv */
// Restoring divider that retires one quotient bit per cycle.
module wc_divider import wc_pkg::*; #(
  parameter int DIVIDEND_W = 45,
  parameter int DIVISOR_W  = 26
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      count;
  logic [DIVIDEND_W-1:0] work;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // One trial subtraction: shift the next dividend bit into the remainder.
  always_comb begin
    trial = {rem, work[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dsr};
    fits  = (trial >= {1'b0, dsr});
  end

  // Step counter; the quotient bits shift into the dividend register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(DIVIDEND_W);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (count != '0) begin
      work <= {work[DIVIDEND_W-2:0], fits};
      rem  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign busy     = (count != '0);
  assign quotient = work;

endmodule

/* hw/rtl/wc_datapath.sv */
// Datapath: window counters, moment accumulators, dividers and output register.
module wc_datapath import wc_pkg::*; #(
  parameter int IMAGE_DIM = 2048,
  parameter int MAX_SPOTS = 1024,
  parameter int FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [HALF_W-1:0]   cfg_wr_data,
  input  logic [COORD_W-1:0]  center_x,
  input  logic [COORD_W-1:0]  center_y,
  input  logic [INTENS_W-1:0] intensity,
  input  wc_cmd_t             cmd,
  output wc_stat_t            stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [CENT_W-1:0]   centroid_x,
  output logic [CENT_W-1:0]   centroid_y,
  output logic [INDEX_W-1:0]  spot_index,
  output logic [STATUS_W-1:0] status
);

  localparam int DIVIDEND_W = MOMENT_W + FRAC_BITS;
  localparam int LIM_W      = SCOORD_W;
  localparam logic [LIM_W-1:0]   IMAGE_LIM = LIM_W'(IMAGE_DIM);
  localparam logic [LIM_W-1:0]   SPOT_LIM  = LIM_W'(MAX_SPOTS);
  localparam logic [CENT_W-1:0]  CENT_SAT  = '1;

  logic [HALF_W-1:0]          half_window;
  logic [HALF_W-1:0]          half_eff;
  logic [HALF_W:0]            last_wide;
  logic [HALF_W-1:0]          last_pos;
  logic [HALF_W-1:0]          row_step;
  logic [HALF_W-1:0]          col_step;
  logic                       col_end;
  logic                       row_end;
  logic signed [SCOORD_W-1:0] coord_x;
  logic signed [SCOORD_W-1:0] coord_y;
  logic signed [PROD_W-1:0]   prod_x;
  logic signed [PROD_W-1:0]   prod_y;
  logic                       outside_now;

  logic                       pipe_valid;
  logic signed [PROD_W-1:0]   pipe_px;
  logic signed [PROD_W-1:0]   pipe_py;
  logic [INTENS_W-1:0]        pipe_w;
  logic                       pipe_outside;

  logic [WEIGHT_W-1:0]        weight_total;
  logic [MOMENT_W-1:0]        row_moment;
  logic [MOMENT_W-1:0]        col_moment;
  logic [INDEX_W-1:0]         window_count;
  logic [INDEX_W:0]           count_inc;
  logic                       outside_hold;
  logic [STATUS_W-1:0]        status_hold;
  logic [INDEX_W-1:0]         index_hold;

  logic                       busy_x;
  logic                       busy_y;
  logic [DIVIDEND_W-1:0]      quot_x;
  logic [DIVIDEND_W-1:0]      quot_y;
  logic [CENT_W-1:0]          sat_x;
  logic [CENT_W-1:0]          sat_y;

  // Half width register, written from the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_window <= HALF_RESET;
    end else if (cfg_wr_en) begin
      half_window <= cfg_wr_data;
    end
  end

  // Clamp the half width and derive the last position inside the window.
  always_comb begin
    priority if (half_window < HALF_MIN) begin
      half_eff = HALF_MIN;
    end else if (half_window > HALF_MAX) begin
      half_eff = HALF_MAX;
    end else begin
      half_eff = half_window;
    end
    last_wide = {half_eff, 1'b0} - (HALF_W+1)'(1);
    last_pos  = last_wide[HALF_W-1:0];
    col_end   = (col_step >= last_pos);
    row_end   = (row_step >= last_pos);
  end

  // Pixel coordinates, their products with the intensity and the image test.
  always_comb begin
    coord_x = SCOORD_W'(center_x) - SCOORD_W'(half_eff) + SCOORD_W'(row_step);
    coord_y = SCOORD_W'(center_y) - SCOORD_W'(half_eff) + SCOORD_W'(col_step);
    prod_x  = coord_x * $signed({1'b0, intensity});
    prod_y  = coord_y * $signed({1'b0, intensity});
    outside_now = (center_x < COORD_W'(half_eff)) ||
                  (center_y < COORD_W'(half_eff)) ||
                  ((LIM_W'(center_x) + LIM_W'(half_eff)) > IMAGE_LIM) ||
                  ((LIM_W'(center_y) + LIM_W'(half_eff)) > IMAGE_LIM);
  end

  // Row and column counters walk the window in raster order.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_step <= '0;
      col_step <= '0;
    end else if (cmd.accept) begin
      if (!col_end) begin
        col_step <= col_step + 1'b1;
      end else begin
        col_step <= '0;
        row_step <= row_end ? '0 : row_step + 1'b1;
      end
    end
  end

  // Product stage between the multipliers and the accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= cmd.accept;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pipe_px      <= prod_x;
      pipe_py      <= prod_y;
      pipe_w       <= intensity;
      pipe_outside <= outside_now;
    end
  end

  // Moment accumulators, wrapping in their widths; cleared when a window closes.
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_total <= '0;
      row_moment   <= '0;
      col_moment   <= '0;
      outside_hold <= 1'b0;
    end else if (cmd.start_div) begin
      weight_total <= '0;
      row_moment   <= '0;
      col_moment   <= '0;
    end else if (pipe_valid) begin
      weight_total <= weight_total + WEIGHT_W'(pipe_w);
      row_moment   <= row_moment + {{(MOMENT_W-PROD_W){pipe_px[PROD_W-1]}}, pipe_px};
      col_moment   <= col_moment + {{(MOMENT_W-PROD_W){pipe_py[PROD_W-1]}}, pipe_py};
      outside_hold <= pipe_outside;
    end
  end

  // Spot counter and the status of the window being divided.
  assign count_inc = {1'b0, window_count} + (INDEX_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
    end else if (cmd.start_div) begin
      if (LIM_W'(count_inc) >= SPOT_LIM) begin
        window_count <= '0;
      end else begin
        window_count <= count_inc[INDEX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      index_hold <= window_count;
      if (outside_hold) begin
        status_hold <= STATUS_OUTSIDE;
      end else if (weight_total == '0) begin
        status_hold <= STATUS_ZERO;
      end else begin
        status_hold <= STATUS_OK;
      end
    end
  end

  // Two dividers run side by side on the scaled moments.
  wc_divider #(
    .DIVIDEND_W (DIVIDEND_W),
    .DIVISOR_W  (WEIGHT_W)
  ) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend ({row_moment, {FRAC_BITS{1'b0}}}),
    .divisor  (weight_total),
    .busy     (busy_x),
    .quotient (quot_x)
  );

  wc_divider #(
    .DIVIDEND_W (DIVIDEND_W),
    .DIVISOR_W  (WEIGHT_W)
  ) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend ({col_moment, {FRAC_BITS{1'b0}}}),
    .divisor  (weight_total),
    .busy     (busy_y),
    .quotient (quot_y)
  );

  // Saturate quotients that do not fit the Q11.8 result.
  always_comb begin
    sat_x = (quot_x[DIVIDEND_W-1:CENT_W] != '0) ? CENT_SAT : quot_x[CENT_W-1:0];
    sat_y = (quot_y[DIVIDEND_W-1:CENT_W] != '0) ? CENT_SAT : quot_y[CENT_W-1:0];
  end

  // Output register; a result waits here until the sink takes the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      centroid_x <= (status_hold == STATUS_OK) ? sat_x : '0;
      centroid_y <= (status_hold == STATUS_OK) ? sat_y : '0;
      spot_index <= index_hold;
      status     <= status_hold;
    end
  end

  always_comb begin
    stat.pixel_last = col_end && row_end;
    stat.div_busy   = busy_x || busy_y;
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

/* hw/rtl/wc_ctrl.sv */
// Controller: sequences pixel intake, the end-of-window division and the result load.
module wc_ctrl import wc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  wc_stat_t stat,
  output wc_cmd_t  cmd
);

  localparam logic [1:0] S_ACCUM  = 2'd0;
  localparam logic [1:0] S_FLUSH  = 2'd1;
  localparam logic [1:0] S_START  = 2'd2;
  localparam logic [1:0] S_DIVIDE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and commands.
  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.start_div = 1'b0;
    cmd.load_out  = 1'b0;
    unique case (state)
      S_ACCUM: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && stat.pixel_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // The last product reaches the accumulators here.
        state_next = S_START;
      end
      S_START: begin
        cmd.start_div = 1'b1;
        state_next    = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (!stat.div_busy && stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_ACCUM;
        end
      end
      default: begin
        state_next = S_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  // No pixel is taken while a division is in flight.
  assert property (@(posedge clk) disable iff (rst) stat.div_busy |-> !in_ready)
    else $error("pixel intake open during division");

  // A division start makes the dividers busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst) cmd.start_div |=> stat.div_busy)
    else $error("dividers not busy after start");

  // A result is loaded only into a free output register after the division.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (stat.out_free && !stat.div_busy))
    else $error("result loaded while output full or division running");

  // The last pixel of a window always leads into the flush cycle.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && stat.pixel_last) |=> (state == S_FLUSH))
    else $error("window end not followed by flush");

endmodule

/* hw/rtl/window_centroid_core.sv */
// Top level of the window centroid core: stream ports, controller and datapath.
// Pixels are taken one per cycle while accumulating, (2*H)^2 per window of side 2*H.
// After the last pixel the result passes through the flush, the start, the
// 37 + FRAC_BITS steps of the bit-serial dividers and the load.
// Input is held off from the flush until the result is loaded.
// Synchronous active-high reset clears the sums, counters and spot index and
// sets the half width register to 11.
module window_centroid_core import wc_pkg::*; #(
  parameter int IMAGE_DIM = 2048,
  parameter int MAX_SPOTS = 1024,
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [HALF_W-1:0] cfg_wr_data,   // half_window
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [39:0]       s_tdata,       // center_x, center_y, intensity, zero pad
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata,       // centroid_x, centroid_y, spot_index
  output logic [STATUS_W-1:0] m_tuser      // status
);

  wc_cmd_t             cmd;
  wc_stat_t            stat;
  logic [CENT_W-1:0]   centroid_x;
  logic [CENT_W-1:0]   centroid_y;
  logic [INDEX_W-1:0]  spot_index;

  wc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wc_datapath #(
    .IMAGE_DIM (IMAGE_DIM),
    .MAX_SPOTS (MAX_SPOTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .center_x    (s_tdata[10:0]),
    .center_y    (s_tdata[21:11]),
    .intensity   (s_tdata[37:22]),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .centroid_x  (centroid_x),
    .centroid_y  (centroid_y),
    .spot_index  (spot_index),
    .status      (m_tuser)
  );

  assign m_tdata = {spot_index, centroid_y, centroid_x};

endmodule
